@@ hw/rtl/rrga_pkg.sv @@
// Shared widths, codes and structs of the rectangle region grid allocator.
`default_nettype none

package rrga_pkg;

	// Default sizes, handed to the top level parameters
	localparam int MAX_ROWS_DEF   = 32;
	localparam int MAX_COLS_DEF   = 32;
	localparam int LABEL_BITS_DEF = 8;

	// Fixed field widths of the channels
	localparam int CMD_W      = 2;
	localparam int COORD_W    = 5;
	localparam int SIZE_W     = 6;
	localparam int LABEL_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// Width for coordinate sums and compares (covers 255 + 63)
	localparam int CALC_W = 10;

	localparam logic [CFG_DATA_W-1:0] ROWS_RST = 5'd31;
	localparam logic [CFG_DATA_W-1:0] COLS_RST = 5'd31;

	typedef enum logic [CMD_W-1:0] {
		CMD_PASTE = 2'd0,
		CMD_ERASE = 2'd1,
		CMD_FIND  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS_IN_USE = 1'd0,
		CFG_COLS_IN_USE = 1'd1
	} cfg_idx_t;

	// Per-row operation handed to the row unit
	typedef struct packed {
		logic               check_en;
		logic               paste_en;
		logic               erase_en;
		logic               find_en;
		logic [COORD_W-1:0] col_lo;
		logic [COORD_W-1:0] col_hi;
		logic [COORD_W-1:0] col_nc;
		logic [COORD_W-1:0] find_lo;
	} row_ctl_t;

	// Per-row status returned by the row unit
	typedef struct packed {
		logic               conflict;
		logic               row_full;
		logic               hit;
		logic [COORD_W-1:0] hit_col;
	} row_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/rrga_if.sv @@
// Valid/ready channel interfaces: configuration writes, commands and results.
`default_nettype none

interface rrga_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rrga_pkg::CFG_IDX_W-1:0]    index;
	logic [rrga_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

interface rrga_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [rrga_pkg::CMD_W-1:0]    command;
	logic [rrga_pkg::COORD_W-1:0]  row;
	logic [rrga_pkg::COORD_W-1:0]  col;
	logic [rrga_pkg::SIZE_W-1:0]   rect_height;
	logic [rrga_pkg::SIZE_W-1:0]   rect_width;
	logic [rrga_pkg::LABEL_W-1:0]  label;

	modport source (output valid, output command, output row, output col,
		output rect_height, output rect_width, output label, input ready);
	modport sink   (input valid, input command, input row, input col,
		input rect_height, input rect_width, input label, output ready);
endinterface

interface rrga_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic [rrga_pkg::COORD_W-1:0]  found_row;
	logic [rrga_pkg::COORD_W-1:0]  found_col;
	logic                          grid_full;

	modport source (output valid, output ok, output found_row, output found_col,
		output grid_full, input ready);
	modport sink   (input valid, input ok, input found_row, input found_col,
		input grid_full, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rrga_ram.sv @@
// Generic single-clock RAM, one write and one read port, registered read data.
`default_nettype none

module rrga_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/rrga_row_unit.sv @@
// Row datapath: checks, pastes, erases and searches one grid row word.
`default_nettype none

module rrga_row_unit #(
	parameter int MAX_COLS   = rrga_pkg::MAX_COLS_DEF,
	parameter int LABEL_BITS = rrga_pkg::LABEL_BITS_DEF,
	localparam int WORD_W = MAX_COLS * LABEL_BITS
) (
	input  wire rrga_pkg::row_ctl_t        ctl,
	input  wire logic [LABEL_BITS-1:0]     label,
	input  wire logic [WORD_W-1:0]         rd_word,
	output logic      [WORD_W-1:0]         wr_word,
	output rrga_pkg::row_stat_t            stat
);

	localparam int CW = rrga_pkg::CALC_W;

	logic [MAX_COLS-1:0] conflict_vec;
	logic [MAX_COLS-1:0] full_vec;
	logic [MAX_COLS-1:0] empty_vec;
	logic [rrga_pkg::COORD_W-1:0] hit_col;

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
		localparam logic [CW-1:0] CIDX = CW'(c);
		logic [LABEL_BITS-1:0] cell_v;
		logic [LABEL_BITS-1:0] new_v;
		logic                  nz;
		logic                  in_rect;
		logic                  active;

		assign cell_v  = rd_word[c*LABEL_BITS +: LABEL_BITS];
		assign nz      = |cell_v;
		assign in_rect = (CIDX >= CW'(ctl.col_lo)) && (CIDX < CW'(ctl.col_hi));
		assign active  = CIDX < CW'(ctl.col_nc);

		assign new_v = (ctl.paste_en && in_rect) ? label :
			(ctl.erase_en && in_rect) ? '0 : cell_v;
		assign wr_word[c*LABEL_BITS +: LABEL_BITS] = new_v;

		assign conflict_vec[c] = ctl.check_en && in_rect && nz;
		assign full_vec[c]     = !active || (|new_v);
		assign empty_vec[c]    = ctl.find_en && active && !nz &&
			(CIDX >= CW'(ctl.find_lo));
	end

	// lowest empty column wins
	always_comb begin
		hit_col = '0;
		for (int c = MAX_COLS - 1; c >= 0; c--) begin
			if (empty_vec[c]) begin
				hit_col = rrga_pkg::COORD_W'(c);
			end
		end
	end

	always_comb begin
		stat          = '0;
		stat.conflict = |conflict_vec;
		stat.row_full = &full_vec;
		stat.hit      = |empty_vec;
		stat.hit_col  = hit_col;
	end

endmodule

`default_nettype wire

@@ hw/rtl/rect_region_grid_allocator_core.sv @@
// Top level of the rectangle region grid allocator: sequencer, row memory, result register.
//
// Usage:
//  - cfg: one beat writes rows_in_use (index 0) or cols_in_use (index 1). Always ready;
//    write only while no command is in flight.
//  - cmd: one beat carries a paste, erase or find command. Ready only while the
//    sequencer is idle; one command is worked at a time.
//  - rsp: one result beat per command, held in an output register until taken.
//    The next command is accepted while a result still waits there.
//  - The grid lives in one RAM word per row; each cycle one row is read, and in the
//    next cycle that row is modified and written back. A paste that lies inside the
//    area with nonzero height first reads its rectangle rows for a collision check,
//    then the sweep over all active rows writes, searches and gathers the full flag.
//  - Reset clears the per-row valid bits, so the grid reads empty at once; no
//    clearing pass is needed. Registers return to 31 rows by 31 columns.
//  - A stalled rsp stalls the sequencer at its final state; nothing is lost.
`default_nettype none

module rect_region_grid_allocator_core #(
	parameter int MAX_ROWS   = rrga_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS   = rrga_pkg::MAX_COLS_DEF,
	parameter int LABEL_BITS = rrga_pkg::LABEL_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rrga_cfg_if.sink   cfg,
	rrga_cmd_if.sink   cmd,
	rrga_rsp_if.source rsp
);

	localparam int AW     = $clog2(MAX_ROWS);
	localparam int PW     = $clog2(MAX_ROWS + 1);
	localparam int WORD_W = MAX_COLS * LABEL_BITS;
	localparam int CW     = rrga_pkg::CALC_W;
	localparam int XW     = rrga_pkg::COORD_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [rrga_pkg::CFG_DATA_W-1:0] rows_q;
	logic [rrga_pkg::CFG_DATA_W-1:0] cols_q;

	// command context, captured on the cmd beat
	logic [rrga_pkg::CMD_W-1:0] cmd_q;
	logic [XW-1:0]              r0_q;
	logic [XW-1:0]              c0_q;
	logic [XW-1:0]              rend_q;  // clipped exclusive end row
	logic [XW-1:0]              cend_q;  // clipped exclusive end column
	logic [LABEL_BITS-1:0]      label_q;
	logic                       in_bounds_q;

	// row pointer and running results
	logic [PW-1:0] ptr_q;
	logic          conflict_q;
	logic          full_q;
	logic          found_q;
	logic [AW-1:0] frow_q;
	logic [XW-1:0] fcol_q;

	// read stage
	logic          vld_s1;
	logic          check_s1;
	logic [AW-1:0] row_s1;
	logic          rowv_s1;

	logic [MAX_ROWS-1:0] row_valid_q;

	// result register
	logic          rsp_valid_q;
	logic          rsp_ok_q;
	logic [XW-1:0] rsp_frow_q;
	logic [XW-1:0] rsp_fcol_q;
	logic          rsp_full_q;

	// ---------------------------------------------------------------- area size
	logic [CW-1:0] rows_w, cols_w;
	logic [XW-1:0] nr_c, nc_c;

	always_comb begin
		rows_w = CW'(rows_q);
		cols_w = CW'(cols_q);
		nr_c   = (rows_w > CW'(MAX_ROWS)) ? XW'(MAX_ROWS) : XW'(rows_w);
		nc_c   = (cols_w > CW'(MAX_COLS)) ? XW'(MAX_COLS) : XW'(cols_w);
	end

	// ---------------------------------------------------------------- config port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= rrga_pkg::ROWS_RST;
			cols_q <= rrga_pkg::COLS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				rrga_pkg::CFG_ROWS_IN_USE: rows_q <= cfg.data;
				rrga_pkg::CFG_COLS_IN_USE: cols_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- command decode
	logic          cmd_acc;
	logic [CW-1:0] r_end_w, c_end_w;
	logic          in_bounds;
	logic          need_check;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;

	always_comb begin
		r_end_w    = CW'(cmd.row) + CW'(cmd.rect_height);
		c_end_w    = CW'(cmd.col) + CW'(cmd.rect_width);
		in_bounds  = (r_end_w <= CW'(nr_c)) && (c_end_w <= CW'(nc_c));
		// only an in-bounds paste with rows to look at needs the collision pass
		need_check = (cmd.command == rrga_pkg::CMD_PASTE) && in_bounds &&
			(cmd.rect_height != '0);
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q       <= cmd.command;
			r0_q        <= cmd.row;
			c0_q        <= cmd.col;
			rend_q      <= (r_end_w > CW'(nr_c)) ? nr_c : XW'(r_end_w);
			cend_q      <= (c_end_w > CW'(nc_c)) ? nc_c : XW'(c_end_w);
			label_q     <= LABEL_BITS'(cmd.label);
			in_bounds_q <= in_bounds;
		end
	end

	// ---------------------------------------------------------------- sequencer
	logic rd_en;
	logic last_check;
	logic sweep_more;
	logic rsp_free;

	assign last_check = (CW'(ptr_q) + CW'(1)) >= CW'(rend_q);
	assign sweep_more = CW'(ptr_q) < CW'(nr_c);
	assign rsp_free   = !rsp_valid_q || rsp.ready;

	always_comb begin
		case (state_q)
			ST_CHECK: rd_en = 1'b1;
			ST_SWEEP: rd_en = sweep_more;
			default:  rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						state_q <= need_check ? ST_CHECK : ST_SWEEP;
						ptr_q   <= need_check ? PW'(cmd.row) : '0;
					end
				end
				ST_CHECK: begin
					if (last_check) begin
						state_q <= ST_SWEEP;
						ptr_q   <= '0;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				ST_SWEEP: begin
					if (sweep_more) begin
						ptr_q <= ptr_q + PW'(1);
					end else begin
						// last row is in the read stage this cycle
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- row memory
	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] rd_eff;
	logic [WORD_W-1:0] wr_word;
	logic              wr_en;

	rrga_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ROWS)
	) u_grid_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (row_s1),
		.wdata (wr_word),
		.re    (rd_en),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		check_s1 <= (state_q == ST_CHECK);
		row_s1   <= ptr_q[AW-1:0];
		rowv_s1  <= row_valid_q[ptr_q[AW-1:0]];
	end

	// a row never written reads as empty
	assign rd_eff = rowv_s1 ? rd_word : '0;

	// only sweep beats write; read and write rows always differ
	assign wr_en = vld_s1 && !check_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[row_s1] <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- row operation
	rrga_pkg::row_ctl_t  ctl;
	rrga_pkg::row_stat_t stat;
	logic                row_in;
	logic                paste_go;

	assign row_in   = (CW'(row_s1) >= CW'(r0_q)) && (CW'(row_s1) < CW'(rend_q));
	assign paste_go = in_bounds_q && !conflict_q;

	always_comb begin
		ctl          = '0;
		ctl.check_en = vld_s1 && check_s1;
		ctl.paste_en = wr_en && (cmd_q == rrga_pkg::CMD_PASTE) && paste_go && row_in;
		ctl.erase_en = wr_en && (cmd_q == rrga_pkg::CMD_ERASE) && row_in;
		ctl.find_en  = wr_en && (cmd_q == rrga_pkg::CMD_FIND) &&
			(CW'(row_s1) >= CW'(r0_q));
		ctl.col_lo   = c0_q;
		ctl.col_hi   = cend_q;
		ctl.col_nc   = nc_c;
		// the start row of a search begins at the start column, later rows at 0
		ctl.find_lo  = (CW'(row_s1) == CW'(r0_q)) ? c0_q : '0;
	end

	rrga_row_unit #(
		.MAX_COLS   (MAX_COLS),
		.LABEL_BITS (LABEL_BITS)
	) u_row_unit (
		.ctl     (ctl),
		.label   (label_q),
		.rd_word (rd_eff),
		.wr_word (wr_word),
		.stat    (stat)
	);

	// ---------------------------------------------------------------- accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conflict_q <= 1'b0;
			full_q     <= 1'b1;
			found_q    <= 1'b0;
		end else if (cmd_acc) begin
			conflict_q <= 1'b0;
			full_q     <= 1'b1;
			found_q    <= 1'b0;
		end else begin
			if (ctl.check_en && stat.conflict) begin
				conflict_q <= 1'b1;
			end
			// every swept row lies in the active area
			if (wr_en && !stat.row_full) begin
				full_q <= 1'b0;
			end
			if (stat.hit && !found_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.hit && !found_q) begin
			frow_q <= row_s1;
			fcol_q <= stat.hit_col;
		end
	end

	// ---------------------------------------------------------------- result register
	logic res_ok;
	logic load_rsp;

	assign load_rsp = (state_q == ST_DONE) && rsp_free;

	always_comb begin
		case (cmd_q)
			rrga_pkg::CMD_PASTE: res_ok = paste_go;
			rrga_pkg::CMD_ERASE: res_ok = 1'b1;
			rrga_pkg::CMD_FIND:  res_ok = found_q;
			default:             res_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_ok_q   <= res_ok;
			rsp_frow_q <= found_q ? XW'(frow_q) : '0;
			rsp_fcol_q <= found_q ? fcol_q : '0;
			rsp_full_q <= full_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.ok        = rsp_ok_q;
	assign rsp.found_row = rsp_frow_q;
	assign rsp.found_col = rsp_fcol_q;
	assign rsp.grid_full = rsp_full_q;

endmodule

`default_nettype wire

@@ hw/rtl/rrga_checker.sv @@
// Port-level assertions for the grid allocator core, with its bind statement.
`default_nettype none

module rrga_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cmd_valid,
	input wire logic                          cmd_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic                          rsp_ok,
	input wire logic [rrga_pkg::COORD_W-1:0]  rsp_found_row,
	input wire logic [rrga_pkg::COORD_W-1:0]  rsp_found_col,
	input wire logic                          rsp_grid_full
);

	logic       cmd_acc;
	logic       rsp_acc;
	logic [1:0] outst_q;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// commands accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (cmd_acc && !rsp_acc) begin
			outst_q <= outst_q + 2'd1;
		end else if (rsp_acc && !cmd_acc) begin
			outst_q <= outst_q - 2'd1;
		end
	end

	// one command in work plus one result waiting, never more
	a_outstanding_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q != 2'd3)
		else $error("more than two commands outstanding");

	a_rsp_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outst_q != 2'd0)
		else $error("result beat without an accepted command");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !cmd_ready && !$rose(rsp_valid))
		else $error("command not held busy for at least one cycle");

	a_fail_zero_coords: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_found_row == '0 && rsp_found_col == '0)
		else $error("failed result carries coordinates");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
			$stable(rsp_found_row) && $stable(rsp_found_col) && $stable(rsp_grid_full))
		else $error("stalled result beat changed");

endmodule

bind rect_region_grid_allocator_core rrga_checker u_rrga_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_ok        (rsp.ok),
	.rsp_found_row (rsp.found_row),
	.rsp_found_col (rsp.found_col),
	.rsp_grid_full (rsp.grid_full)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the rectangle region grid allocator core.
`timescale 1ns / 1ps

module tb;
	import rrga_pkg::*;

	// Command code that the block must treat as a no-op
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Cycles with no beat on any channel before the run is declared hung
	localparam int HANG_LIMIT = 5000;
	// Cycles waited after the last result before the final verdict
	localparam int DRAIN_CYCLES = 80;
	// Length of the deliberate receiver hold-off
	localparam int LONG_HOLD = 400;

	// One command beat; the fields add up to exactly 32 bits
	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [SIZE_W-1:0]  rect_height;
		logic [SIZE_W-1:0]  rect_width;
		logic [LABEL_W-1:0] label;
	} alloc_cmd_t;

	// One result beat
	typedef struct packed {
		logic               ok;
		logic [COORD_W-1:0] found_row;
		logic [COORD_W-1:0] found_col;
		logic               grid_full;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rrga_cfg_if cfg_ch ();
	rrga_cmd_if cmd_ch ();
	rrga_rsp_if rsp_ch ();

	rect_region_grid_allocator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the block: label grid plus the two area registers.
	// Only rows/cols below 31 ever count, so no clamping is needed.
	// ------------------------------------------------------------------
	logic [LABEL_W-1:0]    occ_grid [32][32];
	logic [CFG_DATA_W-1:0] area_rows = ROWS_RST;
	logic [CFG_DATA_W-1:0] area_cols = COLS_RST;

	alloc_cmd_t    cmd_backlog [$];  // commands not yet put on the bus
	alloc_result_t reply_fifo  [$];  // predicted results, oldest first
	alloc_cmd_t    on_bus;           // copy of what the driver is offering

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left = 0;               // receiver hold-off, counted down by the receiver
	int mismatches = 0;
	int quiet_cycles;

	initial begin
		for (int i = 0; i < 32; i++)
			for (int j = 0; j < 32; j++)
				occ_grid[i][j] = '0;
	end

	// Apply one command to the shadow grid and return the result it must produce.
	function automatic alloc_result_t grid_apply(alloc_cmd_t c);
		alloc_result_t r;
		int nr, nc, r0, c0, rend, cend, n, i, j, j0;
		bit fits, hit;
		nr = int'(area_rows);
		nc = int'(area_cols);
		r0 = int'(c.row);
		c0 = int'(c.col);
		rend = r0 + int'(c.rect_height);
		cend = c0 + int'(c.rect_width);
		r = '0;
		hit = 1'b0;
		case (c.command)
			CMD_PASTE: begin
				// bounds first (either edge sticking out fails), then collision scan
				fits = (rend <= nr) && (cend <= nc);
				for (i = r0; i < rend && fits; i++)
					for (j = c0; j < cend && fits; j++)
						if (occ_grid[i][j] != '0)
							fits = 1'b0;
				if (fits)
					for (i = r0; i < rend; i++)
						for (j = c0; j < cend; j++)
							occ_grid[i][j] = c.label;
				r.ok = fits;
			end
			CMD_ERASE: begin
				// clip to the active area
				if (rend > nr)
					rend = nr;
				if (cend > nc)
					cend = nc;
				for (i = r0; i < rend; i++)
					for (j = c0; j < cend; j++)
						occ_grid[i][j] = '0;
				r.ok = 1'b1;
			end
			CMD_FIND: begin
				// row-major from the start cell; a start column past the
				// area just rolls over into the next row
				for (i = r0; i < nr && !hit; i++) begin
					j0 = (i == r0) ? c0 : 0;
					for (j = j0; j < nc && !hit; j++)
						if (occ_grid[i][j] == '0) begin
							hit = 1'b1;
							r.found_row = COORD_W'(i);
							r.found_col = COORD_W'(j);
						end
				end
				r.ok = hit;
			end
			default: ;
		endcase
		n = 0;
		for (i = 0; i < nr; i++)
			for (j = 0; j < nc; j++)
				if (occ_grid[i][j] != '0)
					n++;
		// an empty area counts as full
		r.grid_full = (n == nr * nc);
		return r;
	endfunction

	// Random command, mostly rectangles and searches that sit inside the area.
	function automatic alloc_cmd_t random_cmd(int nr, int nc);
		alloc_cmd_t c;
		int pick, cap;
		c = $urandom();
		pick = $urandom_range(99, 0);
		if (pick < 15)
			return c;  // raw noise: every field takes any value its width allows
		cap = ($urandom_range(9, 0) == 0) ? 32 : 5;
		c.row = COORD_W'($urandom_range(nr, 0));
		c.col = COORD_W'($urandom_range(nc, 0));
		c.rect_height = SIZE_W'($urandom_range(
			(nr - int'(c.row)) < cap ? nr - int'(c.row) : cap, 0));
		c.rect_width  = SIZE_W'($urandom_range(
			(nc - int'(c.col)) < cap ? nc - int'(c.col) : cap, 0));
		if ($urandom_range(9, 0) == 0)
			c.label = '0;
		if (pick < 50)
			c.command = CMD_PASTE;
		else if (pick < 70)
			c.command = CMD_ERASE;
		else if (pick < 96)
			c.command = CMD_FIND;
		else
			c.command = CMD_UNUSED;
		return c;
	endfunction

	// Nothing queued, nothing offered, nothing owed by the block.
	function automatic bit block_quiet();
		return cmd_backlog.size() == 0 && !cmd_ch.valid && reply_fifo.size() == 0;
	endfunction

	// ------------------------------------------------------------------
	// Command driver: holds a beat until it is taken, then maybe gaps.
	// Prediction happens here, at the edge where the beat is accepted.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				reply_fifo.push_back(grid_apply(on_bus));
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					on_bus = cmd_backlog.pop_front();
					cmd_ch.valid       <= 1'b1;
					cmd_ch.command     <= on_bus.command;
					cmd_ch.row         <= on_bus.row;
					cmd_ch.col         <= on_bus.col;
					cmd_ch.rect_height <= on_bus.rect_height;
					cmd_ch.rect_width  <= on_bus.rect_width;
					cmd_ch.label       <= on_bus.label;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: random back-pressure, or a long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Result monitor: every taken beat against the oldest prediction.
	always @(posedge clk) begin : result_monitor
		alloc_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (reply_fifo.size() == 0) begin
				$error("result beat with no command outstanding");
				mismatches++;
			end else begin
				want = reply_fifo.pop_front();
				check_field("ok", want.ok, rsp_ch.ok);
				check_field("found_row", want.found_row, rsp_ch.found_row);
				check_field("found_col", want.found_col, rsp_ch.found_col);
				check_field("grid_full", want.grid_full, rsp_ch.grid_full);
			end
		end
	end

	// Hang detector: any beat on any channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (cfg_ch.valid && cfg_ch.ready) || (cmd_ch.valid && cmd_ch.ready)
				|| (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("rect_region_grid_allocator_core test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing. State is polled on the falling edge so the checks never
	// race the clocked processes; bus changes go out on the rising edge.
	// ------------------------------------------------------------------
	task automatic settle();
		do
			@(negedge clk);
		while (!block_quiet());
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_ROWS_IN_USE)
			area_rows = value;
		else
			area_cols = value;
	endtask

	// Reprogram the area; only legal once every result is back.
	task automatic set_area(logic [CFG_DATA_W-1:0] nrows, logic [CFG_DATA_W-1:0] ncols);
		settle();
		write_reg(CFG_ROWS_IN_USE, nrows);
		write_reg(CFG_COLS_IN_USE, ncols);
		@(negedge clk);
	endtask

	task automatic push_cmd(logic [CMD_W-1:0] op, int r, int c, int h, int w, int lab);
		alloc_cmd_t x;
		x.command     = op;
		x.row         = COORD_W'(r);
		x.col         = COORD_W'(c);
		x.rect_height = SIZE_W'(h);
		x.rect_width  = SIZE_W'(w);
		x.label       = LABEL_W'(lab);
		cmd_backlog.push_back(x);
	endtask

	task automatic push_random(int count);
		for (int k = 0; k < count; k++)
			cmd_backlog.push_back(random_cmd(int'(area_rows), int'(area_cols)));
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_ROWS_IN_USE;
		cfg_ch.data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_PASTE;
		cmd_ch.row = '0;
		cmd_ch.col = '0;
		cmd_ch.rect_height = '0;
		cmd_ch.rect_width = '0;
		cmd_ch.label = '0;
		rsp_ch.ready = 1'b0;
		send_idle_pct = 31;
		recv_idle_pct = 81;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// ---- sender gaps light, receiver stalls heavy ----
		set_area(5'd31, 5'd31);
		// directed corners on the full 31 x 31 area
		push_cmd(CMD_FIND,   0,  0,  0,  0, 8'h00);  // empty grid: first cell
		push_cmd(CMD_PASTE,  0,  0, 31, 31, 8'hff);  // fill the whole area
		push_cmd(CMD_FIND,   0,  0,  0,  0, 8'h00);  // full: search fails
		push_cmd(CMD_PASTE,  0,  0,  1,  1, 8'h01);  // collision
		push_cmd(CMD_ERASE, 30, 30, 63, 63, 8'h00);  // clipped to one corner cell
		push_cmd(CMD_FIND,  31,  0,  0,  0, 8'h00);  // start row past the area
		push_cmd(CMD_FIND,  29, 31,  0,  0, 8'h00);  // start col past area, rolls over
		push_cmd(CMD_PASTE, 30, 30,  1,  1, 8'h00);  // label zero leaves it empty
		push_cmd(CMD_PASTE, 30, 30,  2,  1, 8'h22);  // bottom edge out
		push_cmd(CMD_PASTE, 30, 30,  1,  2, 8'h22);  // right edge out
		push_cmd(CMD_PASTE, 30, 31,  1,  0, 8'h33);  // zero width at the edge
		push_cmd(CMD_PASTE, 31,  0,  0,  5, 8'h33);  // zero height at the edge
		push_cmd(CMD_PASTE,  0,  0, 32, 32, 8'h44);  // 32 x 32, past the area: out
		push_cmd(CMD_UNUSED, 31, 31, 63, 63, 8'hff); // no-op command
		push_cmd(CMD_ERASE,  0,  0, 32, 32, 8'h00);  // clear everything
		push_cmd(CMD_PASTE,  5,  7,  3,  4, 8'h5a);
		push_cmd(CMD_FIND,   5,  7,  0,  0, 8'h00);  // skips past the block
		push_cmd(CMD_PASTE,  5,  7,  1,  1, 8'h80);  // collision inside the block
		push_cmd(CMD_ERASE,  5,  7,  0, 32, 8'h00);  // zero-height erase
		push_cmd(CMD_PASTE,  0,  0,  0,  0, 8'h01);
		push_cmd(CMD_PASTE, 31, 31,  0,  0, 8'h7f);
		push_cmd(CMD_ERASE,  6,  8,  1,  2, 8'h00);
		push_cmd(CMD_FIND,   5,  0,  0,  0, 8'h00);
		push_random(140);
		set_area(5'd4, 5'd6);
		push_random(50);
		set_area(5'd31, 5'd0);  // no columns: empty area
		push_random(20);

		// ---- sender gaps heavy, receiver stalls light ----
		settle();
		send_idle_pct = 81;
		recv_idle_pct = 31;
		set_area(5'd0, 5'd31);  // no rows: empty area
		push_random(20);
		set_area(5'd16, 5'd9);
		// receiver sits out a long stretch while commands keep coming,
		// so the output register fills and the input backs up
		hold_left = LONG_HOLD;
		push_random(150);

		// ---- no idling on either side ----
		settle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_area(5'd1, 5'd1);
		push_random(40);
		set_area(5'd31, 5'd31);  // leftovers from smaller areas come back into view
		push_random(90);
		settle();               // sender waits for every outstanding result
		push_random(90);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && reply_fifo.size() == 0) begin
			$display("rect_region_grid_allocator_core test passed");
		end else begin
			$display("rect_region_grid_allocator_core test failed");
		end
		$finish;
	end

endmodule
